[hdl/cbs_pkg.sv]
`default_nettype none
package cbs_pkg;

    localparam int POLY_LENGTH = 2048;
    localparam int IDX_W       = 11;
    localparam int CNT_W       = (POLY_LENGTH > 2048) ? 12 : 11;
    localparam int COEF_W      = 4;
    localparam int LANES       = 4;
    localparam int GROUP_BYTES = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_ETA1 = 2'd0;
    localparam logic [1:0] MODE_ETA2 = 2'd1;
    localparam logic [1:0] MODE_ETA5 = 2'd2;

    typedef struct packed {
        logic                          pair;
        logic [LANES-1:0][COEF_W-1:0]  coeff;
    } cbs_job_t;

endpackage
`default_nettype wire

[hdl/cbs_front.sv]
`default_nettype none
module cbs_front
    import cbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    input  wire logic [1:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output cbs_job_t        q_job
);

    logic [1:0]                   mode_reg;
    logic [2:0]                   group_cnt_reg;
    logic [2:0]                   group_cnt_next;
    logic [LANES-1:0][COEF_W-1:0] sums_reg;
    logic [LANES-1:0][COEF_W-1:0] sums_next;
    logic [LANES-1:0][COEF_W-1:0] sums_add;
    logic [LANES-1:0][COEF_W-1:0] eta1_coef;
    logic [1:0][COEF_W-1:0]       eta2_coef;
    logic                         take;
    logic                         group_done;

    assign in_ready   = !q_full;
    assign take       = in_valid && in_ready;
    assign group_done = (group_cnt_reg == 3'(GROUP_BYTES - 1));

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            eta1_coef[j] = {3'b0, in_byte[j]} - {3'b0, in_byte[j+4]};
            sums_add[j]  = sums_reg[j] + {3'b0, in_byte[2*j]} - {3'b0, in_byte[2*j+1]};
        end
        for (int j = 0; j < 2; j++)
        begin
            eta2_coef[j] = {3'b0, in_byte[4*j]} + {3'b0, in_byte[4*j+1]}
                         - {3'b0, in_byte[4*j+2]} - {3'b0, in_byte[4*j+3]};
        end
    end

    always_comb
    begin
        q_push         = 1'b0;
        q_job.pair     = 1'b0;
        q_job.coeff    = eta1_coef;
        sums_next      = sums_reg;
        group_cnt_next = group_cnt_reg;
        unique case (mode_reg)
            MODE_ETA1:
            begin
                q_push = take;
            end
            MODE_ETA2:
            begin
                q_push      = take;
                q_job.pair  = 1'b1;
                q_job.coeff = {{2{{COEF_W{1'b0}}}}, eta2_coef[1], eta2_coef[0]};
            end
            MODE_ETA5:
            begin
                q_job.coeff = sums_add;
                if (take)
                begin
                    if (group_done)
                    begin
                        q_push         = 1'b1;
                        sums_next      = '0;
                        group_cnt_next = '0;
                    end
                    else
                    begin
                        sums_next      = sums_add;
                        group_cnt_next = group_cnt_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ETA1;
            group_cnt_reg <= '0;
            sums_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            mode_reg      <= cfg_data;
            group_cnt_reg <= '0;
            sums_reg      <= '0;
        end
        else
        begin
            group_cnt_reg <= group_cnt_next;
            sums_reg      <= sums_next;
        end
    end

endmodule
`default_nettype wire

[hdl/cbs_queue.sv]
`default_nettype none
module cbs_queue
    import cbs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cbs_job_t push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output cbs_job_t      head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cbs_job_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/cbs_back.sv]
`default_nettype none
module cbs_back
    import cbs_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire cbs_job_t      q_job,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [COEF_W-1:0]  out_coef,
    output logic [IDX_W-1:0]   out_index,
    output logic               out_last_run,
    output logic               out_last_poly
);

    cbs_job_t            job_reg;
    logic                job_valid_reg;
    logic [1:0]          pos_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic                valid_reg;
    logic [COEF_W-1:0]   coef_reg;
    logic [IDX_W-1:0]    index_reg;
    logic                last_run_reg;
    logic                last_poly_reg;
    logic [1:0]          last_pos;
    logic                fire;
    logic                job_done;
    logic                idx_wrap;

    assign last_pos  = job_reg.pair ? 2'd1 : 2'd3;
    assign fire      = job_valid_reg && (!valid_reg || out_ready);
    assign job_done  = fire && (pos_reg == last_pos);
    assign q_pop     = !q_empty && (!job_valid_reg || job_done);
    assign idx_wrap  = (idx_reg == CNT_W'(POLY_LENGTH - 1));

    assign out_valid     = valid_reg;
    assign out_coef      = coef_reg;
    assign out_index     = index_reg;
    assign out_last_run  = last_run_reg;
    assign out_last_poly = last_poly_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (fire)
        begin
            coef_reg      <= job_reg.coeff[pos_reg];
            index_reg     <= idx_reg[IDX_W-1:0];
            last_run_reg  <= (pos_reg == last_pos);
            last_poly_reg <= idx_wrap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                job_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (job_done)
            begin
                job_valid_reg <= 1'b0;
            end
            else if (fire)
            begin
                pos_reg <= pos_reg + 2'd1;
            end

            if (fire)
            begin
                idx_reg   <= idx_wrap ? '0 : idx_reg + 1'b1;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[hdl/centered_binomial_sampler.sv]
// Centered binomial sampler: turns random bytes on the slave stream into signed
// coefficients (-5..5) on the master stream, one coefficient per cycle at most.
// In eta 1 and eta 2 the output register is the limit: an eta 1 byte gives four
// coefficients and an eta 2 byte two. An eta 5 group of five input bytes gives
// four results. The front end takes a byte per cycle while a two-entry job
// queue has room, so bytes keep flowing while results wait. The user must write
// sample_mode through cfg_valid/cfg_data only while the block is idle; the block
// itself does not enforce this. A write clears any pending eta 5 group but keeps
// the coefficient index, which wraps at the polynomial length.
`default_nettype none
module centered_binomial_sampler
    import cbs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // coefficient[3:0], coeff_index[14:4], zero[15]
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // last_of_poly
);

    cbs_job_t              push_job;
    cbs_job_t              head_job;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    logic [COEF_W-1:0]     coef;
    logic [IDX_W-1:0]      index;
    logic                  last_poly;

    assign cfg_ready = 1'b1;

    cbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    cbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    cbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_coef      (coef),
        .out_index     (index),
        .out_last_run  (m_tlast),
        .out_last_poly (last_poly)
    );

    assign m_tdata = {1'b0, index, coef};
    assign m_tuser = last_poly;

endmodule
`default_nettype wire

[tb/centered_binomial_sampler_tb.sv]
`timescale 1ns / 1ps

module centered_binomial_sampler_tb;
    import cbs_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PER_PHASE = 80;

    typedef struct {
        logic [COEF_W-1:0] coef;
        logic [IDX_W-1:0]  idx;
        logic              run_end;
        logic              poly_end;
    } coeff_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = MODE_ETA1;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;   // coefficient[3:0], coeff_index[14:4], zero[15]
    logic        m_tlast;
    logic [0:0]  m_tuser;   // last_of_poly

    logic [1:0]                    mode_now = MODE_ETA1;
    int                            group_count = 0;
    logic signed [COEF_W-1:0]      lane_sum [LANES];
    logic [IDX_W-1:0]              next_index = '0;
    coeff_t                        pending_coeffs [$];

    int src_idle = 0;
    int sink_stall = 0;
    int mismatches = 0;
    int bytes_sent = 0;
    int coeffs_checked = 0;
    int poly_wraps = 0;

    centered_binomial_sampler DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall);
    end

    initial
    begin
        for (int j = 0; j < LANES; j++)
        begin
            lane_sum[j] = '0;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic push_coeff(input int value, input logic run_end);
        coeff_t c;
        c.coef     = COEF_W'(value);
        c.idx      = next_index;
        c.run_end  = run_end;
        c.poly_end = (int'(next_index) == POLY_LENGTH - 1);
        pending_coeffs.push_back(c);
        next_index = (int'(next_index) == POLY_LENGTH - 1) ? '0 : next_index + 1'b1;
    endtask

    task automatic clear_group();
        group_count = 0;
        for (int j = 0; j < LANES; j++)
        begin
            lane_sum[j] = '0;
        end
    endtask

    task automatic predict_coeffs(input logic [7:0] b);
        int v;
        case (mode_now)
            MODE_ETA1:
            begin
                for (int j = 0; j < 4; j++)
                begin
                    push_coeff(int'(b[j]) - int'(b[j + 4]), j == 3);
                end
            end
            MODE_ETA2:
            begin
                for (int j = 0; j < 2; j++)
                begin
                    v = int'(b[4 * j]) + int'(b[4 * j + 1])
                        - int'(b[4 * j + 2]) - int'(b[4 * j + 3]);
                    push_coeff(v, j == 1);
                end
            end
            MODE_ETA5:
            begin
                for (int j = 0; j < LANES; j++)
                begin
                    v = int'(lane_sum[j]) + int'(b[2 * j]) - int'(b[2 * j + 1]);
                    lane_sum[j] = COEF_W'(v);
                end
                group_count++;
                if (group_count == GROUP_BYTES)
                begin
                    for (int j = 0; j < LANES; j++)
                    begin
                        push_coeff(int'(lane_sum[j]), j == LANES - 1);
                    end
                    clear_group();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_coeff();
        coeff_t want;
        if (pending_coeffs.size() == 0)
        begin
            report_mismatch($sformatf("unexpected coefficient, data %h", m_tdata));
            return;
        end
        want = pending_coeffs.pop_front();
        coeffs_checked++;
        if (m_tdata[3:0] !== want.coef)
        begin
            report_mismatch($sformatf("coefficient %0d, expected %0d (index %0d)",
                $signed(m_tdata[3:0]), $signed(want.coef), want.idx));
        end
        if (m_tdata[14:4] !== want.idx)
        begin
            report_mismatch($sformatf("coeff_index %0d, expected %0d",
                m_tdata[14:4], want.idx));
        end
        if (m_tlast !== want.run_end)
        begin
            report_mismatch($sformatf("last_of_run %b, expected %b (index %0d)",
                m_tlast, want.run_end, want.idx));
        end
        if (m_tuser[0] !== want.poly_end)
        begin
            report_mismatch($sformatf("last_of_poly %b, expected %b (index %0d)",
                m_tuser[0], want.poly_end, want.idx));
        end
        if (want.poly_end)
        begin
            poly_wraps++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                check_coeff();
            end
            if (cfg_valid && cfg_ready)
            begin
                mode_now = cfg_data;
                clear_group();
            end
            if (s_tvalid && s_tready)
            begin
                predict_coeffs(s_tdata);
            end
        end
    end

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'h00;
                1:       return 8'hFF;
                2:       return 8'h55;
                default: return 8'hAA;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic set_idling(input int src, input int sink);
        src_idle   = src;
        sink_stall = sink;
    endtask

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_coeffs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_eta1();
        set_idling(0, 0);
        write_mode(MODE_ETA1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h0F);
        send_byte(8'hF0);
    endtask

    task automatic test_eta2();
        write_mode(MODE_ETA2);
        send_byte(8'h33);
        send_byte(8'hCC);
        send_byte(8'h96);
    endtask

    task automatic test_eta5_groups();
        write_mode(MODE_ETA5);
        repeat (5) send_byte(8'h55);
        repeat (5) send_byte(8'hAA);
        // leave a group partly filled (two of five bytes), then drop it with a mode write
        send_byte(8'h01);
        send_byte(8'h02);
        write_mode(MODE_ETA1);
        send_byte(8'hF0);
        write_mode(MODE_ETA5);
        repeat (5) send_byte(rand_byte());
    endtask

    task automatic test_unused_mode();
        write_mode(MODE_UNUSED);
        send_byte(8'hFF);
        send_byte(8'h00);
        write_mode(MODE_ETA1);
        send_byte(8'h81);
    endtask

    task automatic test_index_wrap();
        int n;
        set_idling(20, 20);
        settle();
        if (next_index[1] == 1'b0)
        begin
            write_mode(MODE_ETA2);
            send_byte(rand_byte());
        end
        write_mode(MODE_ETA1);
        // advance to index 2043, 2046 or 2047 so one of the next two bytes wraps mid-run
        n = (POLY_LENGTH - 2 - int'(next_index)) / 4;
        repeat (n) send_byte(rand_byte());
        repeat (2) send_byte(rand_byte());
        write_mode(MODE_ETA2);
        repeat (4) send_byte(rand_byte());
    endtask

    task automatic test_random();
        int budget;
        int n;
        logic [1:0] mode;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(50, 0);
                2:       set_idling(0, 50);
                default: set_idling(20, 20);
            endcase
            budget = RANDOM_PER_PHASE;
            while (budget > 0)
            begin
                case ($urandom_range(0, 9))
                    0:       mode = MODE_UNUSED;
                    1, 2, 3: mode = MODE_ETA1;
                    4, 5:    mode = MODE_ETA2;
                    default: mode = MODE_ETA5;
                endcase
                write_mode(mode);
                if (mode == MODE_ETA5)
                begin
                    n = GROUP_BYTES * $urandom_range(1, 4);
                    if ($urandom_range(0, 3) == 0)
                    begin
                        n += $urandom_range(1, GROUP_BYTES - 1);
                    end
                end
                else if (mode == MODE_UNUSED)
                begin
                    n = $urandom_range(1, 3);
                end
                else
                begin
                    n = $urandom_range(4, 16);
                end
                repeat (n) send_byte(rand_byte());
                if (mode != MODE_UNUSED)
                begin
                    budget -= n;
                end
            end
        end
    endtask

    initial
    begin
        apply_reset();
        test_eta1();
        test_eta2();
        test_eta5_groups();
        test_unused_mode();
        test_index_wrap();
        test_random();
        settle();
        $display("Sent %0d bytes over eta 1, eta 2, eta 5 and the unused mode;", bytes_sent);
        $display("checked %0d coefficients across %0d polynomial wraps.",
            coeffs_checked, poly_wraps);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d coefficients still expected", pending_coeffs.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
